@@ design/ipdd_pkg.sv @@
`timescale 1ns / 1ps

package ipdd_pkg;

  // Fixed payload widths of the two channels.
  localparam int unsigned AddrW  = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 4;

  // ASCII codes that the text is built from.
  localparam logic [CharW-1:0] AsciiZero = 8'h30;
  localparam logic [CharW-1:0] AsciiDot  = 8'h2e;

  // Character slot within one byte group: three digit places, then the separator.
  typedef enum logic [1:0] {
    POS_HUN = 2'd0,
    POS_TEN = 2'd1,
    POS_ONE = 2'd2,
    POS_DOT = 2'd3
  } ipdd_pos_e;

  // One address byte, already split into decimal digits.
  // The start slot skips the leading zeros.
  typedef struct packed {
    ipdd_pos_e         start;
    logic [DigitW-1:0] hun;
    logic [DigitW-1:0] ten;
    logic [DigitW-1:0] one;
  } ipdd_byte_t;

  // One queued address: byte 0 is printed first.
  typedef struct packed {
    ipdd_byte_t [3:0] grp;
  } ipdd_entry_t;

endpackage

@@ design/ipdd_channels.sv @@
`timescale 1ns / 1ps

// Address channel: one IPv4 address word per beat.
interface ipdd_in_if import ipdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] ip_address;

  modport source (output valid, output ip_address, input ready);
  modport sink   (input valid, input ip_address, output ready);
endinterface

// Text channel: one ASCII character per beat, with the end-of-text mark.
interface ipdd_out_if import ipdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ design/ipdd_front.sv @@
`timescale 1ns / 1ps

module ipdd_front import ipdd_pkg::*; (
  ipdd_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output ipdd_entry_t entry_o
);

  // Splits one byte into hundreds, tens and ones, and finds the first digit to print.
  function automatic ipdd_byte_t split_byte(input logic [7:0] v);
    ipdd_byte_t        res;
    logic [7:0]        rem;
    logic [DigitW-1:0] ten;
    logic [7:0]        tens_val;
    begin
      if (v >= 8'd200) begin
        res.hun = 4'd2;
        rem     = v - 8'd200;
      end else if (v >= 8'd100) begin
        res.hun = 4'd1;
        rem     = v - 8'd100;
      end else begin
        res.hun = 4'd0;
        rem     = v;
      end
      // The remainder is below 100, so nine compares settle the tens digit.
      ten = 4'd0;
      for (int k = 1; k < 10; k++) begin
        if (rem >= 8'(10 * k)) begin
          ten = 4'(k);
        end
      end
      tens_val = {ten, 3'b000} + {3'b000, ten, 1'b0};
      res.ten  = ten;
      res.one  = 4'(rem - tens_val);
      if (res.hun != 4'd0) begin
        res.start = POS_HUN;
      end else if (ten != 4'd0) begin
        res.start = POS_TEN;
      end else begin
        res.start = POS_ONE;
      end
      return res;
    end
  endfunction

  // Take an address whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Classify all four bytes in parallel.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      entry_o.grp[b] = split_byte(in_i.ip_address[8*b +: 8]);
    end
  end

endmodule

@@ design/ipdd_queue.sv @@
`timescale 1ns / 1ps

module ipdd_queue import ipdd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ipdd_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output ipdd_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ipdd_entry_t         slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill-count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ design/ipdd_back.sv @@
`timescale 1ns / 1ps

module ipdd_back import ipdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  ipdd_entry_t head_i,
  output logic        pop_o,
  ipdd_out_if.source  out_o
);

  logic             started_q, started_d;
  logic [1:0]       grp_q, grp_d;
  ipdd_pos_e        pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;

  ipdd_byte_t       cur;
  ipdd_byte_t       nxt;
  ipdd_pos_e        pos;
  logic             step;
  logic             is_last;

  // Current byte group and slot; a fresh address starts at its first printed digit.
  assign cur     = head_i.grp[grp_q];
  assign nxt     = head_i.grp[grp_q + 2'd1];
  assign pos     = started_q ? pos_q : head_i.grp[0].start;
  assign is_last = (pos == POS_ONE) && (grp_q == 2'd3);

  // Advance whenever an address is queued and the output register is free or draining.
  assign step  = !empty_i && (!out_valid_q || out_o.ready);
  assign pop_o = step && is_last;

  // Sequencer: next slot and the character it produces.
  always_comb begin
    started_d   = started_q;
    grp_d       = grp_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (step) begin
      out_valid_d = 1'b1;
      last_d      = is_last;
      case (pos)
        POS_HUN: char_d = AsciiZero + {4'b0000, cur.hun};
        POS_TEN: char_d = AsciiZero + {4'b0000, cur.ten};
        POS_ONE: char_d = AsciiZero + {4'b0000, cur.one};
        default: char_d = AsciiDot;
      endcase

      if (is_last) begin
        started_d = 1'b0;
        grp_d     = 2'd0;
        pos_d     = POS_HUN;
      end else begin
        started_d = 1'b1;
        case (pos)
          POS_HUN: pos_d = POS_TEN;
          POS_TEN: pos_d = POS_ONE;
          POS_ONE: pos_d = POS_DOT;
          default: begin
            grp_d = grp_q + 2'd1;
            pos_d = nxt.start;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      grp_q       <= 2'd0;
      pos_q       <= POS_HUN;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      grp_q       <= grp_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last_char = last_q;

endmodule

@@ design/ipv4_to_dotted_decimal_unit.sv @@
`timescale 1ns / 1ps

// IPv4 address to dotted-decimal text.
// The in_i channel takes one 32-bit address per beat; the out_o channel gives its
// text as ASCII, one character per beat, with last_char set on the final one.
// The low byte prints first, each byte as one to three digits without leading
// zeros, with '.' between bytes: 7 to 15 beats per address.
// An accepted address is written into the queue; the sequencer takes it from the
// queue head and registers its characters one by one into out_o.
// Throughput: one character per cycle while addresses are queued and out_o.ready
// stays high; the single output register that emits the characters sets this.
// A queue of QueueDepth classified addresses sits between the input side and
// the character sequencer, so addresses keep being taken while text drains.
// When the receiver stalls, the current character holds and the sequencer
// waits; once the queue fills, in_i.ready drops.
// Reset empties the queue and drops out_o.valid; no partial text survives.

module ipv4_to_dotted_decimal_unit import ipdd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipdd_in_if.sink    in_i,
  ipdd_out_if.source out_o
);

  logic        push;
  logic        full;
  logic        pop;
  logic        empty;
  ipdd_entry_t entry;
  ipdd_entry_t head;

  // Input side: digit split of all four bytes.
  ipdd_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  // Queue of classified addresses.
  ipdd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Output side: character sequencer and output register.
  ipdd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ design/ipdd_checker.sv @@
`timescale 1ns / 1ps

module ipdd_checker import ipdd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] character_i,
  input logic             last_char_i
);

  logic       beat;
  logic       prev_dot_q;
  logic [3:0] cnt_q;

  assign beat = out_valid_i && out_ready_i;

  // Track the previous character and the length of the current text.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dot_q <= 1'b0;
      cnt_q      <= 4'd0;
    end else if (beat) begin
      prev_dot_q <= (character_i == AsciiDot);
      cnt_q      <= last_char_i ? 4'd0 : cnt_q + 4'd1;
    end
  end

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(character_i)
      && $stable(last_char_i))
    else $error("output character changed while stalled");

  // The text ends on a digit, never on a separator.
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && last_char_i |-> character_i != AsciiDot)
    else $error("text ended on a separator");

  // A separator is always followed by a digit.
  a_no_double_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && prev_dot_q |-> character_i != AsciiDot)
    else $error("two separators in a row");

  // No address text runs past fifteen characters.
  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && cnt_q == 4'd14 |-> last_char_i)
    else $error("address text longer than fifteen characters");

endmodule

bind ipv4_to_dotted_decimal_unit ipdd_checker u_ipdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .character_i (out_o.character),
  .last_char_i (out_o.last_char)
);
